@@ sv/rsa_pkg.sv @@
// Package for the running statistics accumulator.
// Holds widths, data types, the back-end state codes and reset values.
// No dependencies.
package rsa_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int MEAN_BITS     = SAMPLE_BITS + 8;
  localparam int VAR_BITS      = 2 * SAMPLE_BITS + 15;
  localparam int STD_BITS      = SAMPLE_BITS + 8;
  localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int SUMSQ_BITS    = 2 * SAMPLE_BITS + COUNT_BITS - 1;

  localparam int MAG_BITS      = SUM_BITS - 1;
  localparam int MEAN_DVD_BITS = MAG_BITS + 8;
  localparam int DIV_BITS      = SUMSQ_BITS + 16;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

  localparam int ROOT_STEPS    = (VAR_BITS + 1) / 2;
  localparam int ROOT_RAD_BITS = 2 * ROOT_STEPS;
  localparam int ROOT_REM_BITS = ROOT_STEPS + 2;
  localparam int ROOT_CNT_BITS = $clog2(ROOT_STEPS + 1);

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [SUMSQ_BITS-1:0]  sumsq_t;
  typedef logic signed [MEAN_BITS-1:0]   mean_t;
  typedef logic        [VAR_BITS-1:0]    var_t;
  typedef logic        [STD_BITS-1:0]    std_t;

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef struct packed {
    count_t  count;
    sum_t    sum;
    sumsq_t  sumsq;
    sample_t lowest;
    sample_t highest;
    logic    dropped;
  } stat_t;

  typedef struct packed {
    logic                    start;
    logic [DIV_CNT_BITS-1:0] steps;
  } div_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEAN,
    BK_ESQ,
    BK_SQUARE,
    BK_DIFF,
    BK_ROOT,
    BK_DONE
  } bk_state_t;

  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  localparam stat_t STAT_EMPTY = '{
    count:   '0,
    sum:     '0,
    sumsq:   '0,
    lowest:  SAMPLE_MAX,
    highest: SAMPLE_MIN,
    dropped: 1'b0
  };

endpackage

@@ sv/rsa_if.sv @@
// Channel interfaces for the running statistics accumulator.
// rsa_in_if carries samples and commands, rsa_out_if carries results.
// Depends on rsa_pkg.
interface rsa_in_if import rsa_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  sample_t sample;

  modport source (output valid, opcode, sample, input ready);
  modport sink   (input valid, opcode, sample, output ready);
endinterface

interface rsa_out_if import rsa_pkg::*; ();
  logic    valid;
  logic    ready;
  count_t  sample_count;
  mean_t   mean_q8;
  var_t    variance_q16;
  std_t    std_dev_q8;
  sample_t minimum;
  sample_t maximum;
  logic    saturated;

  modport source (output valid, sample_count, mean_q8, variance_q16, std_dev_q8,
                  minimum, maximum, saturated, input ready);
  modport sink   (input valid, sample_count, mean_q8, variance_q16, std_dev_q8,
                  minimum, maximum, saturated, output ready);
endinterface

@@ sv/rsa_front.sv @@
// Front end: accepts transactions, updates count, sums, min, max and drop flag, or clears them.
// Pushes the updated statistics snapshot into the queue.
// Depends on rsa_pkg and rsa_in_if.
module rsa_front import rsa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rsa_in_if.sink   in_chan,
  input  logic     q_full,
  output logic     q_push,
  output stat_t    q_data
);

  stat_t                         st_r;
  stat_t                         st_nxt;
  logic                          accept;
  logic signed [2*SAMPLE_BITS-1:0] square;

  always_comb begin
    in_chan.ready = !q_full;
    accept        = in_chan.valid && !q_full;
    q_push        = accept;
    square        = in_chan.sample * in_chan.sample;
    st_nxt        = st_r;
    if (in_chan.opcode == OP_CLEAR) begin
      st_nxt = STAT_EMPTY;
    end else if (&st_r.count) begin
      st_nxt.dropped = 1'b1;
    end else begin
      st_nxt.count = st_r.count + 1'b1;
      st_nxt.sum   = st_r.sum + SUM_BITS'(in_chan.sample);
      st_nxt.sumsq = st_r.sumsq + SUMSQ_BITS'($unsigned(square));
      if (in_chan.sample < st_r.lowest) begin
        st_nxt.lowest = in_chan.sample;
      end
      if (in_chan.sample > st_r.highest) begin
        st_nxt.highest = in_chan.sample;
      end
    end
    q_data = st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STAT_EMPTY;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ sv/rsa_fifo.sv @@
// Snapshot queue between front and back end.
// Depth FIFO_DEPTH, push and pop in the same cycle allowed.
// Depends on rsa_pkg.
module rsa_fifo import rsa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  stat_t wr_data,
  input  logic  pop,
  output stat_t rd_data,
  output logic  full,
  output logic  empty
);

  stat_t                    mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_r;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_nxt;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_r;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_nxt;
  logic [FIFO_CNT_BITS-1:0] cnt_r;
  logic [FIFO_CNT_BITS-1:0] cnt_nxt;

  always_comb begin
    full    = (cnt_r == FIFO_CNT_BITS'(FIFO_DEPTH));
    empty   = (cnt_r == '0);
    rd_data = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ sv/rsa_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Dividend is left aligned; steps sets how many bits are developed.
// Depends on rsa_pkg.
module rsa_div import rsa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  div_req_t            req,
  input  logic [DIV_BITS-1:0] dividend,
  input  count_t              divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] quotient
);

  logic                    busy_r;
  logic                    busy_nxt;
  logic                    done_r;
  logic                    done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [DIV_CNT_BITS-1:0] cnt_nxt;
  count_t                  rem_r;
  count_t                  rem_nxt;
  logic [DIV_BITS-1:0]     dvd_r;
  logic [DIV_BITS-1:0]     dvd_nxt;
  logic [DIV_BITS-1:0]     quo_r;
  logic [DIV_BITS-1:0]     quo_nxt;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;
  logic                    ge;

  always_comb begin
    trial    = {rem_r, dvd_r[DIV_BITS-1]};
    diff     = trial - {1'b0, divisor};
    ge       = (trial >= {1'b0, divisor});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      dvd_nxt = {dvd_r[DIV_BITS-2:0], 1'b0};
      quo_nxt = {quo_r[DIV_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    done     = done_r;
    quotient = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

endmodule

@@ sv/rsa_back.sv @@
// Back end: takes snapshots from the queue, derives mean, variance, deviation.
// Sequences the shared divider and a digit-by-digit square root; owns the result register.
// Depends on rsa_pkg, rsa_out_if and rsa_div.
module rsa_back import rsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  stat_t     q_data,
  output logic      q_pop,
  rsa_out_if.source out_chan
);

  bk_state_t                  state_r;
  bk_state_t                  state_nxt;
  stat_t                      snap_r;
  stat_t                      snap_nxt;
  logic                       neg_r;
  logic                       neg_nxt;
  logic [MEAN_BITS-1:0]       q_r;
  logic [MEAN_BITS-1:0]       q_nxt;
  var_t                       e2_r;
  var_t                       e2_nxt;
  var_t                       m2_r;
  var_t                       m2_nxt;
  var_t                       var_r;
  var_t                       var_nxt;
  logic [ROOT_RAD_BITS-1:0]   rad_r;
  logic [ROOT_RAD_BITS-1:0]   rad_nxt;
  logic [ROOT_REM_BITS-1:0]   rrem_r;
  logic [ROOT_REM_BITS-1:0]   rrem_nxt;
  logic [ROOT_STEPS-1:0]      root_r;
  logic [ROOT_STEPS-1:0]      root_nxt;
  logic [ROOT_CNT_BITS-1:0]   step_r;
  logic [ROOT_CNT_BITS-1:0]   step_nxt;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       out_load;
  count_t                     out_count_r;
  mean_t                      out_mean_r;
  var_t                       out_var_r;
  std_t                       out_std_r;
  sample_t                    out_min_r;
  sample_t                    out_max_r;
  logic                       out_sat_r;

  div_req_t                   div_req;
  logic [DIV_BITS-1:0]        div_dvd;
  logic                       div_done;
  logic [DIV_BITS-1:0]        div_quo;

  logic [MAG_BITS-1:0]        in_mag;
  sum_t                       in_neg_sum;
  logic [DIV_BITS-1:0]        mean_dvd;
  logic [2*MEAN_BITS-1:0]     prod;
  var_t                       diff;
  logic [ROOT_REM_BITS-1:0]   rcat;
  logic [ROOT_REM_BITS-1:0]   rtrial;
  mean_t                      mean_val;

  rsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (snap_r.count),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    snap_nxt  = snap_r;
    neg_nxt   = neg_r;
    q_nxt     = q_r;
    e2_nxt    = e2_r;
    m2_nxt    = m2_r;
    var_nxt   = var_r;
    rad_nxt   = rad_r;
    rrem_nxt  = rrem_r;
    root_nxt  = root_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    div_req   = '0;

    in_neg_sum = -q_data.sum;
    in_mag     = (q_data.sum < 0) ? in_neg_sum[MAG_BITS-1:0] : q_data.sum[MAG_BITS-1:0];
    mean_dvd   = DIV_BITS'({in_mag, 8'b0}) << (DIV_BITS - MEAN_DVD_BITS);
    div_dvd    = {snap_r.sumsq, 16'b0};
    prod       = q_r * q_r;
    diff       = (e2_r > m2_r) ? e2_r - m2_r : '0;
    rcat       = {rrem_r[ROOT_REM_BITS-3:0], rad_r[ROOT_RAD_BITS-1 -: 2]};
    rtrial     = {root_r, 2'b01};
    mean_val   = neg_r ? -mean_t'(q_r) : mean_t'(q_r);

    out_valid_nxt = out_valid_r && !out_chan.ready;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          snap_nxt = q_data;
          neg_nxt  = (q_data.sum < 0);
          if (q_data.count == '0) begin
            q_nxt     = '0;
            var_nxt   = '0;
            root_nxt  = '0;
            state_nxt = BK_DONE;
          end else begin
            div_req.start = 1'b1;
            div_req.steps = DIV_CNT_BITS'(MEAN_DVD_BITS);
            div_dvd       = mean_dvd;
            state_nxt     = BK_MEAN;
          end
        end
      end
      BK_MEAN: begin
        if (div_done) begin
          q_nxt         = div_quo[MEAN_BITS-1:0];
          div_req.start = 1'b1;
          div_req.steps = DIV_CNT_BITS'(DIV_BITS);
          state_nxt     = BK_ESQ;
        end
      end
      BK_ESQ: begin
        if (div_done) begin
          e2_nxt    = div_quo[VAR_BITS-1:0];
          state_nxt = BK_SQUARE;
        end
      end
      BK_SQUARE: begin
        m2_nxt    = prod[VAR_BITS-1:0];
        state_nxt = BK_DIFF;
      end
      BK_DIFF: begin
        var_nxt   = diff;
        rad_nxt   = ROOT_RAD_BITS'(diff);
        rrem_nxt  = '0;
        root_nxt  = '0;
        step_nxt  = ROOT_CNT_BITS'(ROOT_STEPS);
        state_nxt = BK_ROOT;
      end
      BK_ROOT: begin
        rad_nxt  = {rad_r[ROOT_RAD_BITS-3:0], 2'b00};
        step_nxt = step_r - 1'b1;
        if (rcat >= rtrial) begin
          rrem_nxt = rcat - rtrial;
          root_nxt = {root_r[ROOT_STEPS-2:0], 1'b1};
        end else begin
          rrem_nxt = rcat;
          root_nxt = {root_r[ROOT_STEPS-2:0], 1'b0};
        end
        if (step_r == ROOT_CNT_BITS'(1)) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    out_chan.valid        = out_valid_r;
    out_chan.sample_count = out_count_r;
    out_chan.mean_q8      = out_mean_r;
    out_chan.variance_q16 = out_var_r;
    out_chan.std_dev_q8   = out_std_r;
    out_chan.minimum      = out_min_r;
    out_chan.maximum      = out_max_r;
    out_chan.saturated    = out_sat_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
    neg_r  <= neg_nxt;
    q_r    <= q_nxt;
    e2_r   <= e2_nxt;
    m2_r   <= m2_nxt;
    var_r  <= var_nxt;
    rad_r  <= rad_nxt;
    rrem_r <= rrem_nxt;
    root_r <= root_nxt;
    if (out_load) begin
      out_count_r <= snap_r.count;
      out_mean_r  <= mean_val;
      out_var_r   <= var_r;
      out_std_r   <= STD_BITS'(root_r);
      out_min_r   <= snap_r.lowest;
      out_max_r   <= snap_r.highest;
      out_sat_r   <= snap_r.dropped;
    end
  end

endmodule

@@ sv/running_statistics_accumulator.sv @@
// Top level of the running statistics accumulator.
// Instantiates rsa_front, rsa_fifo and rsa_back; depends on rsa_pkg and rsa_if.
//
//   channel   direction  payload                                          accepted when
//   in_chan   input      opcode, sample                                   valid && ready
//   out_chan  output     sample_count, mean_q8, variance_q16, std_dev_q8, valid && ready
//                        minimum, maximum, saturated
//
// The front end takes one transaction per cycle while the two-entry queue has room.
// Each non-empty result needs, in the back end, a 39-step and a
// 63-step pass of the shared restoring divider, one multiply, and 24 square-root steps.
// An empty result (count zero) skips the divider and square root and goes straight to BK_DONE.
// Synchronous active-low reset clears all statistics; no clearing pass is needed.
// The result register holds its transaction while out_chan.ready is low; the back end
// keeps working on the next snapshot and waits only to load the register.
module running_statistics_accumulator import rsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rsa_in_if.sink    in_chan,
  rsa_out_if.source out_chan
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  stat_t q_wr_data;
  stat_t q_rd_data;

  logic [2*STD_BITS+1:0] sd_sq;
  logic [2*STD_BITS+1:0] sd1_sq;
  logic [STD_BITS:0]     sd_plus1;

  rsa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  rsa_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  rsa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  always_comb begin
    sd_plus1 = {1'b0, out_chan.std_dev_q8} + 1'b1;
    sd_sq    = out_chan.std_dev_q8 * out_chan.std_dev_q8;
    sd1_sq   = sd_plus1 * sd_plus1;
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.sample_count == '0 |->
      out_chan.mean_q8 == '0 && out_chan.variance_q16 == '0 && out_chan.std_dev_q8 == '0)
    else $error("empty statistics report nonzero mean, variance or deviation");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      sd_sq <= (2*STD_BITS+2)'(out_chan.variance_q16) &&
      sd1_sq > (2*STD_BITS+2)'(out_chan.variance_q16))
    else $error("deviation is not the floor square root of variance");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.sample_count != '0 |-> out_chan.minimum <= out_chan.maximum)
    else $error("minimum exceeds maximum with samples present");

  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.saturated |-> &out_chan.sample_count)
    else $error("saturation reported with count below full");

endmodule
